// ===== rtl/lre_pkg.sv =====
package lre_pkg;

    localparam int DENS_W  = 40;
    localparam int COEF_W  = 32;
    localparam int CUR_W   = 18;
    localparam int PWR_W   = 32;
    localparam int IDX_W   = 4;

    localparam logic [PWR_W-1:0] LRE_POWER_SCALE = 32'd65536;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_INJECTION    = 4'd0;
    localparam logic [IDX_W-1:0] REG_CARRIER_DEC  = 4'd1;
    localparam logic [IDX_W-1:0] REG_CARRIER_GAIN = 4'd2;
    localparam logic [IDX_W-1:0] REG_PHOTON_GAIN  = 4'd3;
    localparam logic [IDX_W-1:0] REG_TRANSPARENCY = 4'd4;
    localparam logic [IDX_W-1:0] REG_COMPRESSION  = 4'd5;
    localparam logic [IDX_W-1:0] REG_SPONTANEOUS  = 4'd6;
    localparam logic [IDX_W-1:0] REG_PHOTON_DEC   = 4'd7;

    // Multiply operations, in the order the sequencer runs them
    typedef enum logic [3:0] {
        OP_DEN, OP_GC, OP_GP, OP_XC, OP_XP,
        OP_INJ, OP_DEC, OP_SP, OP_LOSS, OP_PWR
    } t_op;

    typedef struct packed {
        logic [COEF_W-1:0] inj;
        logic [COEF_W-1:0] cdec;
        logic [COEF_W-1:0] cgain;
        logic [COEF_W-1:0] pgain;
        logic [DENS_W-1:0] ntr;
        logic [COEF_W-1:0] comp;
        logic [COEF_W-1:0] spon;
        logic [COEF_W-1:0] pdec;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_start;
        t_op  mul_op;
        logic div_start;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/laser_rate_equation_step.sv =====
// One forward-Euler step of the single-mode laser rate equations per input
// transfer: the drive current (microamps) advances carrier and photon density
// (Q16.24, saturating) and gives optical power. One item is in work at a time,
// and each takes ten 40x40 products, each run as four 32x32 partial products
// through one shared multiplier, and a restoring division for the compressed
// gain. A finished result waits in the output register while the next item
// is taken. Configuration registers must only be written while the block is
// idle.
module laser_rate_equation_step #(
    parameter logic [31:0] POWER_SCALE = lre_pkg::LRE_POWER_SCALE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // [17:0] drive_current
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [39:0] carrier_density, [79:40] photon_density, [111:80] output_power
    output logic [111:0]                m_axis_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lre_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [39:0]                 i_cfg_data
);
    import lre_pkg::*;

    t_cfg        r_cfg;
    logic        r_ovalid;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [39:0] w_carrier, w_photon;
    logic [31:0] w_power;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INJECTION:    r_cfg.inj   <= i_cfg_data[31:0];
                REG_CARRIER_DEC:  r_cfg.cdec  <= i_cfg_data[31:0];
                REG_CARRIER_GAIN: r_cfg.cgain <= i_cfg_data[31:0];
                REG_PHOTON_GAIN:  r_cfg.pgain <= i_cfg_data[31:0];
                REG_TRANSPARENCY: r_cfg.ntr   <= i_cfg_data;
                REG_COMPRESSION:  r_cfg.comp  <= i_cfg_data[31:0];
                REG_SPONTANEOUS:  r_cfg.spon  <= i_cfg_data[31:0];
                REG_PHOTON_DEC:   r_cfg.pdec  <= i_cfg_data[31:0];
                default:          r_cfg       <= r_cfg;
            endcase
        end
    end

    // Output valid: set on new result, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    lre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (r_ovalid && !m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lre_dp #(
        .POWER_SCALE (POWER_SCALE)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cur     (s_axis_tdata[17:0]),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_carrier (w_carrier),
        .o_photon  (w_photon),
        .o_power   (w_power)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {w_power, w_photon, w_carrier};

endmodule

// ===== rtl/lre_ctrl.sv =====
module lre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_busy,
    input  lre_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lre_pkg::t_cmd o_cmd
);
    import lre_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL_GO   = 7'b0000010,
        ST_MUL_WAIT = 7'b0000100,
        ST_DIV_GO   = 7'b0001000,
        ST_DIV_WAIT = 7'b0010000,
        ST_UPD      = 7'b0100000,
        ST_OUT      = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // Sequence one step: multiplies, division, update, power, transfer out
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_op = r_op;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_DEN;
                    n_state    = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    case (r_op)
                        OP_DEN:  n_state = ST_DIV_GO;
                        OP_LOSS: n_state = ST_UPD;
                        OP_PWR:  n_state = ST_OUT;
                        default: begin
                            n_op    = t_op'(r_op + 4'd1);
                            n_state = ST_MUL_GO;
                        end
                    endcase
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_op    = OP_GC;
                    n_state = ST_MUL_GO;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_op         = OP_PWR;
                n_state      = ST_MUL_GO;
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DEN;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

// ===== rtl/lre_dp.sv =====
module lre_dp #(
    parameter logic [31:0] POWER_SCALE = lre_pkg::LRE_POWER_SCALE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lre_pkg::t_cfg                 i_cfg,
    input  logic [lre_pkg::CUR_W-1:0]     i_cur,
    input  lre_pkg::t_cmd                 i_cmd,
    output lre_pkg::t_sts                 o_sts,
    output logic [lre_pkg::DENS_W-1:0]    o_carrier,
    output logic [lre_pkg::DENS_W-1:0]    o_photon,
    output logic [lre_pkg::PWR_W-1:0]     o_power
);
    import lre_pkg::*;

    localparam logic [40:0] ONE_Q24 = 41'h1000000;

    // State and intermediate terms
    logic [17:0] r_cur;
    logic [39:0] r_n, r_p, r_eff, r_gc, r_gp, r_dec, r_sp, r_loss;
    logic [40:0] r_den;
    logic [55:0] r_xc, r_xp;
    logic [41:0] r_inj;
    logic [31:0] r_pwr;
    logic [39:0] r_on, r_opd;
    logic [31:0] r_opw;

    // Shared multiplier: 40x40 as four 32x32 partial products
    logic [39:0] r_ma, r_mb;
    t_op         r_mop;
    logic        r_mbusy, r_pv;
    logic [1:0]  r_mcnt, r_psh;
    logic [63:0] r_prod;
    logic [79:0] r_acc;

    // Restoring divider, one quotient bit a cycle
    logic        r_dbusy;
    logic [5:0]  r_dcnt;
    logic [40:0] r_rem;
    logic [63:0] r_quo;

    logic        w_above;
    logic [39:0] w_diff, w_a, w_b;
    logic [31:0] w_ca, w_cb;
    logic [79:0] w_padd, w_full;
    logic [1:0]  w_shsel;
    logic        w_mdone, w_ddone;
    logic [41:0] w_trial, w_rnext;
    logic        w_ge;
    logic [58:0] w_xcs, w_xps, w_nsum, w_psum;
    logic [39:0] w_nsat, w_psat;

    // Distance from transparency
    always_comb begin
        w_above = r_n >= i_cfg.ntr;
        w_diff  = w_above ? r_n - i_cfg.ntr : i_cfg.ntr - r_n;
    end

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            OP_DEN:  begin w_a = {8'd0, i_cfg.comp};  w_b = r_p;               end
            OP_GC:   begin w_a = {8'd0, i_cfg.cgain}; w_b = r_eff;             end
            OP_GP:   begin w_a = {8'd0, i_cfg.pgain}; w_b = r_eff;             end
            OP_XC:   begin w_a = w_diff;              w_b = r_gc;              end
            OP_XP:   begin w_a = w_diff;              w_b = r_gp;              end
            OP_INJ:  begin w_a = {8'd0, i_cfg.inj};   w_b = {22'd0, r_cur};    end
            OP_DEC:  begin w_a = {8'd0, i_cfg.cdec};  w_b = r_n;               end
            OP_SP:   begin w_a = {8'd0, i_cfg.spon};  w_b = r_n;               end
            OP_LOSS: begin w_a = {8'd0, i_cfg.pdec};  w_b = r_p;               end
            OP_PWR:  begin w_a = r_p;                 w_b = {8'd0, POWER_SCALE}; end
            default: begin w_a = '0;                  w_b = '0;                end
        endcase
    end

    // Partial product chunks and accumulation
    always_comb begin
        w_ca    = r_mcnt[1] ? {24'd0, r_ma[39:32]} : r_ma[31:0];
        w_cb    = r_mcnt[0] ? {24'd0, r_mb[39:32]} : r_mb[31:0];
        w_shsel = {1'b0, r_psh[0]} + {1'b0, r_psh[1]};
        case (w_shsel)
            2'd0:    w_padd = {16'd0, r_prod};
            2'd1:    w_padd = {r_prod[47:0], 32'd0};
            2'd2:    w_padd = {r_prod[15:0], 64'd0};
            default: w_padd = '0;
        endcase
        w_full  = r_acc + w_padd;
        w_mdone = r_pv && (r_psh == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_pv    <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_pv <= r_mbusy;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) r_mbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma  <= w_a;
            r_mb  <= w_b;
            r_mop <= i_cmd.mul_op;
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= w_full;
        end
        r_prod <= w_ca * w_cb;
        r_psh  <= r_mcnt;
    end

    // Write each finished product to its term
    always_ff @(posedge i_clk) begin
        if (w_mdone) begin
            case (r_mop)
                OP_DEN:  r_den  <= {1'b0, w_full[71:32]} + ONE_Q24;
                OP_GC:   r_gc   <= w_full[71:32];
                OP_GP:   r_gp   <= w_full[71:32];
                OP_XC:   r_xc   <= w_full[79:24];
                OP_XP:   r_xp   <= w_full[79:24];
                OP_INJ:  r_inj  <= w_full[49:8];
                OP_DEC:  r_dec  <= w_full[71:32];
                OP_SP:   r_sp   <= w_full[71:32];
                OP_LOSS: r_loss <= w_full[71:32];
                OP_PWR:  r_pwr  <= (|w_full[79:56]) ? '1 : w_full[55:24];
                default: r_pwr  <= r_pwr;
            endcase
        end
    end

    // Divider step: P * 2^24 / den
    always_comb begin
        w_trial = {r_rem, r_quo[63]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_rnext = w_ge ? w_trial - {1'b0, r_den} : w_trial;
        w_ddone = r_dbusy && (r_dcnt == 6'd63);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= '0;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + 6'd1;
            if (w_ddone) r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= {r_p, 24'd0};
        end else if (r_dbusy) begin
            r_rem <= w_rnext[40:0];
            r_quo <= {r_quo[62:0], w_ge};
            if (w_ddone) r_eff <= {r_quo[38:0], w_ge};
        end
    end

    // Euler update with saturation at zero and full scale
    always_comb begin
        w_xcs  = w_above ? {3'd0, r_xc} : 59'd0 - {3'd0, r_xc};
        w_xps  = w_above ? {3'd0, r_xp} : 59'd0 - {3'd0, r_xp};
        w_nsum = {19'd0, r_n} + {17'd0, r_inj} - {19'd0, r_dec} - w_xcs;
        w_psum = {19'd0, r_p} + w_xps + {19'd0, r_sp} - {19'd0, r_loss};
        if (w_nsum[58])           w_nsat = '0;
        else if (|w_nsum[57:40])  w_nsat = '1;
        else                      w_nsat = w_nsum[39:0];
        if (w_psum[58])           w_psat = '0;
        else if (|w_psum[57:40])  w_psat = '1;
        else                      w_psat = w_psum[39:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_p <= '0;
        end else if (i_cmd.update) begin
            r_n <= w_nsat;
            r_p <= w_psat;
        end
    end

    // Capture input, hold result for transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_cur <= i_cur;
        if (i_cmd.emit) begin
            r_on  <= r_n;
            r_opd <= r_p;
            r_opw <= r_pwr;
        end
    end

    assign o_sts.mul_done = w_mdone;
    assign o_sts.div_done = w_ddone;
    assign o_carrier = r_on;
    assign o_photon  = r_opd;
    assign o_power   = r_opw;

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_start |-> !r_mbusy && !r_pv)
        else $error("multiply started while busy");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_dbusy && !r_mbusy)
        else $error("division started while a unit is busy");

    a_eff_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |=> r_eff <= r_p)
        else $error("effective density exceeds photon density");

endmodule
